// File: rtl/ir_range_filter_lookup_core_assert.svh
// Assertion macros for the infrared range filter core.
`ifndef IR_RANGE_FILTER_LOOKUP_CORE_ASSERT_SVH
`define IR_RANGE_FILTER_LOOKUP_CORE_ASSERT_SVH
// Checks that a condition implies another on the same edge.
`define IRF_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);
// Checks that a condition implies another on the next edge.
`define IRF_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`endif

// File: rtl/irfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irfl_pkg
// Shared constants and types for the infrared range filter core.
// ----------------------------------------------------------------------------
package irfl_pkg;
   localparam int TABLE_LEN_DEF = 256;
   localparam int CHANNELS_DEF  = 4;
   localparam int FRAC_BITS_DEF = 16;

   localparam int CH_W    = 2;
   localparam int LVL_W   = 12;
   localparam int IDX_W   = 8;
   localparam int ENT_W   = 13;
   localparam int REG_W   = 17;
   localparam int CSR_A_W = 2;

   localparam logic [CSR_A_W-1:0] CSR_KALMAN_EN = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_CAL_MODE  = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_Q         = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_P         = 2'd3;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TABLE  = 1'b1;

   typedef struct packed {
      logic [CH_W-1:0]  channel;
      logic [IDX_W-1:0] distance;
      logic [LVL_W-1:0] raw;
      logic             valid;
   } rsp_type;
endpackage

// File: rtl/ir_range_filter_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_range_filter_lookup_core
// Four-channel infrared range Kalman filter with distance table search.
// ----------------------------------------------------------------------------
// req_ channel: a sample (req_type 0) or a table write (req_type 1). A table
// write gives no result; the next request may follow on the next edge. A
// sample reads the channel state (S_RDW, S_RD), runs a restoring gain divide
// at one quotient bit a cycle, two multiplies and the history update (S_MUL1,
// S_MUL2, S_CAL), then a table search with one memory read per step: both
// table ends (S_T0, S_T0W, S_T1, S_T1W), then up to log2(TABLE_LEN)-1
// halving steps, each a read (S_SRD) and a check (S_SCHK). In calibration
// mode the table search is skipped.
// Items are taken one at a time; rsp_ holds a result in an output register,
// and the next request is taken as soon as that register is free again
// or is being emptied in the same transfer.
// Reset: a clearing pass over all channels returns channel state to estimate
// 2000, covariance 1.0, history 0; requests wait for it. Configuration returns
// to defaults. Table contents are undefined until written.
// A stalled rsp_ready holds the result and blocks the next request.
// csr_ writes are taken at once and must only occur while idle.
// ----------------------------------------------------------------------------
module ir_range_filter_lookup_core #(
   parameter int TABLE_LEN = irfl_pkg::TABLE_LEN_DEF,
   parameter int CHANNELS  = irfl_pkg::CHANNELS_DEF,
   parameter int FRAC_BITS = irfl_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [irfl_pkg::CH_W-1:0]     req_channel,
   input  logic [irfl_pkg::LVL_W-1:0]    req_ambient_level,
   input  logic [irfl_pkg::LVL_W-1:0]    req_lit_level,
   input  logic [irfl_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [irfl_pkg::ENT_W-1:0]    req_entry_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [irfl_pkg::CH_W-1:0]     rsp_out_channel,
   output logic [irfl_pkg::IDX_W-1:0]    rsp_distance_mm,
   output logic [irfl_pkg::LVL_W-1:0]    rsp_raw_level,
   output logic                          rsp_distance_valid,
   input  logic                          csr_write_en,
   input  logic [irfl_pkg::CSR_A_W-1:0]  csr_index,
   input  logic [irfl_pkg::REG_W-1:0]    csr_write_data
);
   import irfl_pkg::*;
`include "ir_range_filter_lookup_core_assert.svh"

   localparam int F      = FRAC_BITS;
   localparam int EST_W  = LVL_W + F;
   localparam int COV_W  = F + 2;
   localparam int K_W    = F + 1;
   localparam int TI_W   = $clog2(TABLE_LEN);
   localparam int TA_W   = $clog2(CHANNELS) + TI_W;
   localparam int CS_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SP_W   = TI_W + 2;
   localparam int DC_W   = $clog2(K_W + 1);
   localparam int DEN_W  = COV_W + 1;
   localparam logic [COV_W-1:0] COV_MAX = '1;
   localparam logic [EST_W-1:0] EST_RST = EST_W'(2000) << F;
   localparam logic [COV_W-1:0] ONE_FX  = COV_W'(1) << F;
   localparam logic [K_W-1:0]   K_ONE   = K_W'(1) << F;
   localparam longint QRAW = ((longint'(1) << F) + 50) / 100;
   localparam longint PRAW = ((longint'(1) << F) * 2 + 5) / 10;
   localparam logic [REG_W-1:0] Q_RST = (QRAW > 131071) ? '1 : REG_W'(QRAW);
   localparam logic [REG_W-1:0] P_RST = (PRAW > 131071) ? '1 : REG_W'(PRAW);
   localparam logic [TI_W-1:0] POS_START = TI_W'((TABLE_LEN - 1) / 2);
   localparam logic [TI_W-1:0] POS_LAST  = TI_W'(TABLE_LEN - 1);
   localparam logic [TI_W-1:0] POS_PEN   = TI_W'(TABLE_LEN - 2);
   localparam logic [SP_W-1:0] SPAN_START = SP_W'(TABLE_LEN / 2);
   localparam logic [DC_W-1:0] DIV_STEPS  = DC_W'(K_W);
   // x/10 as (x*52429)>>19, exact for x below 2^18
   localparam int CALM_W = LVL_W + 22;
   localparam logic [CALM_W-1:0] DIV10_MUL = CALM_W'(52429);

   localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_DIV = 4'd2, S_MUL1 = 4'd3,
      S_MUL2 = 4'd4, S_CAL = 4'd5, S_T0 = 4'd6, S_T1 = 4'd7, S_T1W = 4'd8,
      S_SRD = 4'd9, S_SCHK = 4'd10, S_DONE = 4'd11, S_CLR = 4'd12, S_T0W = 4'd13,
      S_RDW = 4'd14;

   logic [3:0] state_ff, state_in;

   // configuration
   logic             ken_ff, cal_ff;
   logic [REG_W-1:0] q_ff, p_ff;

   // channel state memory and table memory
   logic [EST_W+COV_W+LVL_W-1:0] chmem [CHANNELS];
   logic [EST_W+COV_W+LVL_W-1:0] ch_rd_ff;
   logic [ENT_W-1:0]            tmem [CHANNELS*TABLE_LEN];
   logic [ENT_W-1:0]            t_rd_ff;

   logic [CS_W-1:0]  clr_ff;
   logic [CS_W-1:0]  ch_ff;
   logic [LVL_W-1:0] lvl_ff;
   logic [EST_W-1:0] est_ff;
   logic [COV_W-1:0] cp_ff;
   logic [LVL_W-1:0] hist_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [K_W-1:0]   k_ff;
   logic [DC_W-1:0]  dcnt_ff;
   logic [EST_W-1:0] diff_ff;
   logic             up_ff;
   logic [LVL_W-1:0] raw_ff;
   logic [TI_W-1:0]  pos_ff;
   logic [SP_W-1:0]  span_ff;
   logic             rsp_v_ff;
   rsp_type          rsp_ff;

   logic ch_ok;
   logic req_xfer, rsp_xfer, tw_ok;
   assign ch_ok    = (32'(req_channel) < CHANNELS);
   assign req_ready = (state_ff == S_IDLE) && (!rsp_v_ff || rsp_ready);
   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_v_ff && rsp_ready;
   assign tw_ok    = ch_ok && (32'(req_entry_index) < TABLE_LEN);

   logic [TA_W-1:0] t_waddr, t_raddr;
   logic [TI_W-1:0] t_ridx;
   assign t_waddr = TA_W'(req_channel) * TA_W'(TABLE_LEN) + TA_W'(req_entry_index);
   assign t_raddr = TA_W'(ch_ff) * TA_W'(TABLE_LEN) + TA_W'(t_ridx);

   always_comb begin
      unique case (state_ff)
         S_T0:    t_ridx = '0;
         S_T1:    t_ridx = POS_PEN;
         default: t_ridx = pos_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_xfer && req_type == REQ_TABLE && tw_ok) begin
         tmem[t_waddr] <= req_entry_value;
      end
      t_rd_ff <= tmem[t_raddr];
   end

   // channel state write-back
   logic                         ch_we;
   logic [CS_W-1:0]              ch_wa;
   logic [EST_W+COV_W+LVL_W-1:0] ch_wd;
   logic [LVL_W-1:0]             hist_new;
   always_ff @(posedge clock) begin
      if (ch_we) begin
         chmem[ch_wa] <= ch_wd;
      end
      ch_rd_ff <= chmem[ch_ff];
   end

   // arithmetic
   logic [LVL_W-1:0]   level;
   logic [COV_W:0]     cp_sum;
   logic [DEN_W-1:0]   den_sum;
   logic [DEN_W+1:0]   trial;
   logic [K_W+EST_W-1:0] prod1;
   logic [K_W+COV_W-1:0] prod2;
   logic [EST_W-1:0]   step;
   logic [LVL_W+4:0]   cal_sum;
   logic [CALM_W-1:0]  cal_mul;
   logic [LVL_W-1:0]   cal_q;
   logic [EST_W-1:0]   cur_est;
   logic [COV_W-1:0]   cur_cov;
   logic [LVL_W-1:0]   cur_hist;
   logic [SP_W-1:0]    half;
   logic [SP_W:0]      pos_move;
   logic [SP_W-1:0]    span_next;
   logic [EST_W-1:0]   z;

   assign level   = (req_lit_level > req_ambient_level) ?
                    (req_lit_level - req_ambient_level) : '0;
   assign z       = EST_W'(lvl_ff) << F;
   assign {cur_est, cur_cov, cur_hist} = ch_rd_ff;
   assign cp_sum  = {1'b0, cur_cov} + (COV_W+1)'(q_ff);
   assign den_sum = DEN_W'(cp_ff) + DEN_W'(p_ff);
   assign trial   = {1'b0, rem_ff, 1'b0} - {2'b00, den_ff};
   assign prod1   = k_ff * diff_ff;
   assign prod2   = (K_ONE - k_ff) * cp_ff;
   assign step    = EST_W'(prod1 >> F);
   assign cal_sum = (LVL_W+5)'(raw_ff) * (LVL_W+5)'(3) + (LVL_W+5)'(hist_ff) * (LVL_W+5)'(7);
   assign cal_mul = CALM_W'(cal_sum) * DIV10_MUL;
   assign cal_q   = LVL_W'(cal_mul >> 19);
   assign half    = span_ff >> 1;
   assign span_next = (span_ff + 1'b1) >> 1;

   always_comb begin
      if (t_rd_ff > ENT_W'(raw_ff)) begin
         pos_move = (SP_W+1)'(pos_ff) + (SP_W+1)'(half);
      end else begin
         pos_move = (SP_W+1)'(pos_ff) - (SP_W+1)'(half);
      end
   end

   logic [TI_W-1:0] pos_clamp;
   always_comb begin
      if (pos_move[SP_W]) begin
         pos_clamp = '0;
      end else if (pos_move > (SP_W+1)'(POS_LAST)) begin
         pos_clamp = POS_LAST;
      end else begin
         pos_clamp = TI_W'(pos_move);
      end
   end

   always_comb begin
      hist_new = cal_ff ? cal_q : raw_ff;
      ch_we = 1'b0;
      ch_wa = ch_ff;
      ch_wd = {est_ff, cp_ff, hist_new};
      if (state_ff == S_CLR) begin
         ch_we = 1'b1;
         ch_wa = clr_ff;
         ch_wd = {EST_RST, ONE_FX, LVL_W'(0)};
      end else if (state_ff == S_CAL) begin
         ch_we = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR:  if (32'(clr_ff) == CHANNELS - 1) state_in = S_IDLE;
         S_IDLE: if (req_xfer && ch_ok && req_type == REQ_SAMPLE) state_in = S_RDW;
         S_RDW:  state_in = S_RD;
         S_RD:   state_in = S_DIV;
         S_DIV:  if (dcnt_ff == '0) state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_CAL;
         S_CAL:  state_in = cal_ff ? S_DONE : S_T0;
         S_T0:   state_in = S_T0W;
         S_T0W:  state_in = (t_rd_ff < ENT_W'(raw_ff)) ? S_DONE : S_T1;
         S_T1:   state_in = S_T1W;
         S_T1W:  state_in = (t_rd_ff > ENT_W'(raw_ff)) ? S_DONE : S_SRD;
         S_SRD:  state_in = S_SCHK;
         S_SCHK: begin
            if (t_rd_ff == ENT_W'(raw_ff) || span_next <= SP_W'(1)) state_in = S_DONE;
            else state_in = S_SRD;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         ken_ff   <= 1'b1;
         cal_ff   <= 1'b0;
         q_ff     <= Q_RST;
         p_ff     <= P_RST;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) clr_ff <= clr_ff + 1'b1;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_KALMAN_EN: ken_ff <= csr_write_data[0];
               CSR_CAL_MODE:  cal_ff <= csr_write_data[0];
               CSR_Q:         q_ff   <= csr_write_data;
               CSR_P:         p_ff   <= csr_write_data;
               default:       ;
            endcase
         end
         if (state_ff == S_DONE) rsp_v_ff <= 1'b1;
         else if (rsp_xfer) rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ch_ff  <= CS_W'(req_channel);
         lvl_ff <= level;
      end
      unique case (state_ff)
         S_RD: begin
            cp_ff   <= (cp_sum > (COV_W+1)'(COV_MAX)) ? COV_MAX : COV_W'(cp_sum);
            est_ff  <= cur_est;
            hist_ff <= cur_hist;
            dcnt_ff <= DIV_STEPS;
            k_ff    <= '0;
         end
         S_DIV: begin
            // restoring divide: integer bit first, then one fraction bit a cycle
            if (dcnt_ff == DIV_STEPS) begin
               den_ff <= den_sum;
               if (den_sum != '0 && DEN_W'(cp_ff) >= den_sum) begin
                  rem_ff <= DEN_W'(cp_ff) - den_sum;
                  k_ff   <= K_W'(1);
               end else begin
                  rem_ff <= DEN_W'(cp_ff);
                  k_ff   <= '0;
               end
            end else if (dcnt_ff != '0) begin
               if (!trial[DEN_W+1]) begin
                  rem_ff <= trial[DEN_W-1:0];
                  k_ff   <= {k_ff[K_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_ff << 1;
                  k_ff   <= {k_ff[K_W-2:0], 1'b0};
               end
            end else if (den_ff == '0) begin
               k_ff <= '0;
            end
            if (dcnt_ff != '0) dcnt_ff <= dcnt_ff - 1'b1;
            diff_ff <= (z >= est_ff) ? z - est_ff : est_ff - z;
            up_ff   <= (z >= est_ff);
         end
         S_MUL1: begin
            if (ken_ff) begin
               est_ff <= up_ff ? est_ff + step : est_ff - step;
               cp_ff  <= COV_W'(prod2 >> F);
            end else begin
               est_ff <= z;
               cp_ff  <= cur_cov;
            end
         end
         S_MUL2: raw_ff <= est_ff[F +: LVL_W];
         S_CAL: begin
            if (cal_ff) raw_ff <= cal_q;
            pos_ff  <= POS_START;
            span_ff <= SPAN_START;
         end
         S_T0W:  rsp_ff.distance <= '0;
         S_T1W:  rsp_ff.distance <= IDX_W'(POS_LAST);
         S_SCHK: begin
            if (t_rd_ff == ENT_W'(raw_ff)) begin
               rsp_ff.distance <= IDX_W'(pos_ff);
            end else begin
               pos_ff          <= pos_clamp;
               span_ff         <= span_next;
               rsp_ff.distance <= IDX_W'(pos_clamp);
            end
         end
         default: ;
      endcase
      if (state_ff == S_DONE) begin
         rsp_ff.channel <= CH_W'(ch_ff);
         rsp_ff.raw     <= raw_ff;
         rsp_ff.valid   <= !cal_ff;
         if (cal_ff) rsp_ff.distance <= '0;
      end
   end

   assign rsp_valid          = rsp_v_ff;
   assign rsp_out_channel    = rsp_ff.channel;
   assign rsp_distance_mm    = rsp_ff.distance;
   assign rsp_raw_level      = rsp_ff.raw;
   assign rsp_distance_valid = rsp_ff.valid;

   logic cal_rsp;
   assign cal_rsp = rsp_v_ff && !rsp_ff.valid;

   `IRF_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE, "ready outside idle")
   `IRF_ASSERT_NEXT(a_done_valid, clock, reset, state_ff == S_DONE, rsp_v_ff, "result lost")
   `IRF_ASSERT_IMP(a_cal_flag, clock, reset, cal_rsp, rsp_ff.distance == '0, "cal distance")
endmodule

// File: test/ir_range_filter_lookup_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_range_filter_lookup_core_tb
// Self-checking bench for the infrared range filter and table search core.
// Fills all four distance tables, then runs directed and random samples and
// table writes over several register settings. Every sample accepted is fed
// to a local Kalman and search predictor; rsp_ transfers are checked in order.
// ----------------------------------------------------------------------------
module ir_range_filter_lookup_core_tb;
   import irfl_pkg::*;

   localparam int NCH      = 4;
   localparam int TLEN     = 256;
   localparam int FB       = 16;
   localparam int LIMIT    = 2000000;
   localparam int SETTLE   = 80;
   localparam int N_PHASES = 8;
   localparam int PER_PHASE = 9;
   localparam logic [63:0] COV_SAT = (64'd1 << (FB + 2)) - 1;
   localparam logic [63:0] ONE     = 64'd1 << FB;

   typedef struct {
      logic             kind;
      logic [CH_W-1:0]  ch;
      logic [LVL_W-1:0] amb;
      logic [LVL_W-1:0] lit;
      logic [IDX_W-1:0] idx;
      logic [ENT_W-1:0] val;
   } range_req_type;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_ready;
   logic                req_type = 0;
   logic [CH_W-1:0]     req_channel = 0;
   logic [LVL_W-1:0]    req_ambient_level = 0;
   logic [LVL_W-1:0]    req_lit_level = 0;
   logic [IDX_W-1:0]    req_entry_index = 0;
   logic [ENT_W-1:0]    req_entry_value = 0;
   logic                rsp_valid;
   logic                rsp_ready = 0;
   logic [CH_W-1:0]     rsp_out_channel;
   logic [IDX_W-1:0]    rsp_distance_mm;
   logic [LVL_W-1:0]    rsp_raw_level;
   logic                rsp_distance_valid;
   logic                csr_write_en = 0;
   logic [CSR_A_W-1:0]  csr_index = 0;
   logic [REG_W-1:0]    csr_write_data = 0;

   ir_range_filter_lookup_core u_top (.*);

   // predictor state
   logic              kal_en;
   logic              cal_mode;
   logic [63:0]       q_noise, p_noise;
   logic [63:0]       est_fx [NCH];
   logic [63:0]       cov_fx [NCH];
   logic [11:0]       raw_hist [NCH];
   logic [ENT_W-1:0]  dist_tab [NCH][TLEN];

   range_req_type  pending_reqs [$];
   rsp_type     expected_rsps [$];
   int          errors = 0;
   int          cycles = 0;
   int          samples_sent = 0, writes_sent = 0, rsps_seen = 0;
   int          phase = 0;
   int          send_idle_pct = 7, recv_idle_pct = 77;
   int          hold_cnt = 0;
   bit          hold_done = 0;
   bit          req_fire = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned search_table(input logic [11:0] v, input int ch);
      int pos, span;
      logic [ENT_W-1:0] e;
      if (v > dist_tab[ch][0]) return 0;
      if (v < dist_tab[ch][TLEN-2]) return TLEN - 1;
      pos = (TLEN - 1) / 2;
      span = TLEN / 2;
      forever begin
         e = dist_tab[ch][pos];
         if (e == v) break;
         if (e > v) pos += span / 2;
         else pos -= span / 2;
         if (pos < 0) pos = 0;
         if (pos > TLEN - 1) pos = TLEN - 1;
         span = (span + 1) / 2;
         if (span <= 1) break;
      end
      return pos;
   endfunction

   function automatic rsp_type filter_sample(input int ch, input logic [11:0] amb,
                                             input logic [11:0] lit);
      logic [63:0] z, cp, den, k, stp;
      logic [11:0] lvl, raw;
      rsp_type r;
      lvl = (lit > amb) ? lit - amb : 12'd0;
      z = 64'(lvl) << FB;
      if (kal_en) begin
         cp = cov_fx[ch] + q_noise;
         if (cp > COV_SAT) cp = COV_SAT;
         den = cp + p_noise;
         k = (den != 0) ? (cp << FB) / den : 64'd0;
         if (z >= est_fx[ch]) begin
            stp = (k * (z - est_fx[ch])) >> FB;
            est_fx[ch] = est_fx[ch] + stp;
         end else begin
            stp = (k * (est_fx[ch] - z)) >> FB;
            est_fx[ch] = est_fx[ch] - stp;
         end
         cov_fx[ch] = ((ONE - k) * cp) >> FB;
      end else begin
         est_fx[ch] = z;
      end
      raw = est_fx[ch][FB+11:FB];
      r.channel = CH_W'(ch);
      if (!cal_mode) begin
         raw_hist[ch] = raw;
         r.distance = IDX_W'(search_table(raw, ch));
         r.valid = 1'b1;
      end else begin
         raw = 12'((32'(raw) * 3 + 32'(raw_hist[ch]) * 7) / 10);
         raw_hist[ch] = raw;
         r.distance = '0;
         r.valid = 1'b0;
      end
      r.raw = raw;
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      range_req_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_reqs.pop_front();
            req_type          <= it.kind;
            req_channel       <= it.ch;
            req_ambient_level <= it.amb;
            req_lit_level     <= it.lit;
            req_entry_index   <= it.idx;
            req_entry_value   <= it.val;
            req_valid         <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off while the sender keeps going
   always @(negedge clock) begin
      if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
      else if (phase == 0 && !hold_done && pending_reqs.size() > 40) begin
         hold_cnt <= 1500;
         hold_done <= 1;
      end
      rsp_ready <= !reset && hold_cnt == 0 && $urandom_range(99) >= recv_idle_pct;
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type exp_r;
      cycles <= cycles + 1;
      req_fire = req_valid && req_ready && !reset;
      if (req_fire) begin
         if (req_type == REQ_TABLE) begin
            dist_tab[req_channel][req_entry_index] = req_entry_value;
            writes_sent++;
         end else begin
            expected_rsps.push_back(filter_sample(req_channel, req_ambient_level,
                                                  req_lit_level));
            samples_sent++;
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsps_seen++;
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer: ch %0d dist %0d raw %0d v %0b",
               rsp_out_channel, rsp_distance_mm, rsp_raw_level, rsp_distance_valid);
         end else begin
            exp_r = expected_rsps.pop_front();
            if (rsp_out_channel !== exp_r.channel || rsp_distance_mm !== exp_r.distance ||
                rsp_raw_level !== exp_r.raw || rsp_distance_valid !== exp_r.valid) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp ch %0d dist %0d raw %0d v %0b, got %0d %0d %0d %0b",
                     exp_r.channel, exp_r.distance, exp_r.raw, exp_r.valid,
                     rsp_out_channel, rsp_distance_mm, rsp_raw_level, rsp_distance_valid);
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_sample(input int ch, input int amb, input int lit);
      range_req_type it;
      it.kind = REQ_SAMPLE; it.ch = CH_W'(ch); it.amb = LVL_W'(amb); it.lit = LVL_W'(lit);
      it.idx = IDX_W'($urandom); it.val = ENT_W'($urandom);
      pending_reqs.push_back(it);
   endtask

   task automatic push_write(input int ch, input int idx, input int val);
      range_req_type it;
      it.kind = REQ_TABLE; it.ch = CH_W'(ch); it.idx = IDX_W'(idx); it.val = ENT_W'(val);
      it.amb = LVL_W'($urandom); it.lit = LVL_W'($urandom);
      pending_reqs.push_back(it);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_A_W-1:0] idx, input int val);
      @(negedge clock);
      csr_write_en = 1; csr_index = idx; csr_write_data = REG_W'(val);
      case (idx)
         CSR_KALMAN_EN: kal_en = val[0];
         CSR_CAL_MODE:  cal_mode = val[0];
         CSR_Q:         q_noise = 64'(val);
         default:       p_noise = 64'(val);
      endcase
      @(negedge clock);
      csr_write_en = 0;
   endtask

   task automatic set_regs(input int ke, input int cm, input int q, input int p);
      csr_write(CSR_KALMAN_EN, ke);
      csr_write(CSR_CAL_MODE, cm);
      csr_write(CSR_Q, q);
      csr_write(CSR_P, p);
   endtask

   initial begin
      int amb;
      kal_en = 1; cal_mode = 0;
      q_noise = (ONE + 50) / 100;
      p_noise = (ONE * 2 + 5) / 10;
      for (int c = 0; c < NCH; c++) begin
         est_fx[c] = 2000 * ONE; cov_fx[c] = ONE; raw_hist[c] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // descending tables, every entry written before any search
      for (int c = 0; c < NCH; c++)
         for (int i = 0; i < TLEN; i++) push_write(c, i, 4000 - i * 15);

      // directed: level extremes, clamp, table ends
      push_sample(0, 0, 4095);
      push_sample(1, 4095, 0);
      push_sample(2, 4095, 4095);
      push_sample(3, 0, 0);
      push_sample(0, 12'h555, 12'hAAA);
      push_sample(1, 12'hAAA, 12'h555);
      push_write(2, 0, 8191);
      push_write(2, 255, 0);
      push_sample(2, 0, 4095);
      push_sample(3, 0, 175);
      push_sample(3, 100, 100);
      push_write(2, 0, 4000);

      for (phase = 0; phase < N_PHASES; phase++) begin
         wait_idle();
         send_idle_pct = (phase < 3) ? 7 : (phase < 6) ? 77 : 0;
         recv_idle_pct = (phase < 3) ? 77 : (phase < 6) ? 7 : 0;
         case (phase)
            0: set_regs(1, 0, 655, 13107);
            1: set_regs(0, 0, 0, 1);
            2: set_regs(1, 1, 131071, 131071);
            3: set_regs(1, 0, 0, 1);
            4: set_regs(0, 1, 655, 13107);
            5: set_regs(1, 0, 131071, 1);
            default: set_regs($urandom_range(1), $urandom_range(1),
                              $urandom_range(131071), $urandom_range(131071, 1));
         endcase
         for (int n = 0; n < PER_PHASE; n++) begin
            if ($urandom_range(99) < 10) begin
               push_write($urandom_range(3), $urandom_range(255),
                  ($urandom_range(99) < 30) ? $urandom_range(8191) :
                  4000 - $urandom_range(255) * 15);
            end else begin
               amb = ($urandom_range(99) < 70) ? $urandom_range(255) : $urandom_range(4095);
               push_sample($urandom_range(3), amb, $urandom_range(4095));
            end
         end
      end

      wait_idle();
      $display("%0d samples and %0d table writes sent, %0d results checked",
         samples_sent, writes_sent, rsps_seen);
      $display("%0d register settings, filter on/off, calibration on/off", N_PHASES + 1);
      errors += expected_rsps.size();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d errors", errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
